[rtl/skrt_pkg.sv]
// ----------------------------------------------------------------------------
// skrt_pkg
// Shared types and constants of the sorted key record table.
// ----------------------------------------------------------------------------
package skrt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int REQ_W    = 2;
    localparam int KEY_W    = 31;
    localparam int YEAR_W   = 16;
    localparam int HANDLE_W = 32;
    localparam int STAT_W   = 2;
    localparam int USED_W   = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_INS,
        S_FIND,
        S_DEL,
        S_DONE
    } t_state;

    // read address relative to the next pointer value
    typedef enum logic [1:0] {
        RA_BELOW,
        RA_AT,
        RA_ABOVE
    } t_rsel;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [YEAR_W-1:0]   year;
        logic [HANDLE_W-1:0] handle;
    } t_rec;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [KEY_W-1:0]    key;
        logic [YEAR_W-1:0]   year;
        logic [HANDLE_W-1:0] name_handle;
    } t_req_item;

    typedef struct packed {
        logic    start;
        logic    ptr_inc;
        logic    ptr_dec;
        logic    rd_en;
        t_rsel   rd_sel;
        logic    wr_en;
        logic    wr_new;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    st_we;
        t_status st_val;
        logic    cap_found;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_req req_type;
        logic full;
        logic ptr_zero;
        logic ptr_ge2;
        logic at_cnt;
        logic last;
        logic p2_lt_cnt;
        logic rd_vld;
        logic key_ge;
        logic key_eq;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/skrt_if.sv]
// ----------------------------------------------------------------------------
// skrt_req_if / skrt_rsp_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface skrt_req_if;
    logic                          valid;
    logic                          ready;
    logic [skrt_pkg::REQ_W-1:0]    req_type;
    logic [skrt_pkg::KEY_W-1:0]    key;
    logic [skrt_pkg::YEAR_W-1:0]   year;
    logic [skrt_pkg::HANDLE_W-1:0] name_handle;

    modport source (output valid, req_type, key, year, name_handle, input ready);
    modport sink   (input valid, req_type, key, year, name_handle, output ready);
endinterface

interface skrt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [skrt_pkg::STAT_W-1:0]   status;
    logic [skrt_pkg::YEAR_W-1:0]   found_year;
    logic [skrt_pkg::HANDLE_W-1:0] found_handle;
    logic [skrt_pkg::USED_W-1:0]   entries_used;

    modport source (output valid, status, found_year, found_handle, entries_used,
                    input ready);
    modport sink   (input valid, status, found_year, found_handle, entries_used,
                    output ready);
endinterface

[rtl/skrt_ram.sv]
// ----------------------------------------------------------------------------
// skrt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module skrt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/skrt_dpath.sv]
// ----------------------------------------------------------------------------
// skrt_dpath
// Request registers, pointer and count, record RAM and response register.
// ----------------------------------------------------------------------------
module skrt_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  skrt_pkg::t_req_item  i_item,
    input  skrt_pkg::t_dp_cmd    i_cmd,
    output skrt_pkg::t_dp_sts    o_sts,
    skrt_rsp_if.source           o_rsp
);

    localparam int CW = skrt_pkg::CNT_W;
    localparam int IW = skrt_pkg::IDX_W;

    skrt_pkg::t_req                   r_req_type;
    logic [skrt_pkg::KEY_W-1:0]       r_key;
    logic [skrt_pkg::YEAR_W-1:0]      r_year;
    logic [skrt_pkg::HANDLE_W-1:0]    r_handle;
    logic [CW-1:0]                    r_ptr, n_ptr;
    logic [CW-1:0]                    r_cnt, n_cnt;
    logic                             r_rd_vld;
    skrt_pkg::t_status                r_status;
    logic [skrt_pkg::YEAR_W-1:0]      r_fy;
    logic [skrt_pkg::HANDLE_W-1:0]    r_fh;
    logic                             r_out_valid;
    logic [skrt_pkg::STAT_W-1:0]      r_out_status;
    logic [skrt_pkg::YEAR_W-1:0]      r_out_year;
    logic [skrt_pkg::HANDLE_W-1:0]    r_out_handle;
    logic [skrt_pkg::USED_W-1:0]      r_out_used;

    logic [CW-1:0]    rd_ptr;
    logic [CW:0]      ptr_x;
    logic [CW:0]      cnt_x;
    skrt_pkg::t_rec   rd_rec;
    skrt_pkg::t_rec   wr_rec;

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.start) begin
            n_ptr = (skrt_pkg::t_req'(i_item.req_type) == skrt_pkg::REQ_INSERT) ?
                    r_cnt : '0;
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + CW'(1);
        end else if (i_cmd.ptr_dec) begin
            n_ptr = r_ptr - CW'(1);
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            skrt_pkg::RA_BELOW: rd_ptr = n_ptr - CW'(1);
            skrt_pkg::RA_AT:    rd_ptr = n_ptr;
            skrt_pkg::RA_ABOVE: rd_ptr = n_ptr + CW'(1);
            default:            rd_ptr = n_ptr;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    assign wr_rec = i_cmd.wr_new ? skrt_pkg::t_rec'{r_key, r_year, r_handle} : rd_rec;

    skrt_ram #(
        .WIDTH ($bits(skrt_pkg::t_rec)),
        .DEPTH (skrt_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_ptr[IW-1:0]),
        .i_wr_data (wr_rec),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_ptr[IW-1:0]),
        .o_rd_data (rd_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ptr    <= n_ptr;
            r_cnt    <= n_cnt;
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req_type <= skrt_pkg::t_req'(i_item.req_type);
            r_key      <= i_item.key;
            r_year     <= i_item.year;
            r_handle   <= i_item.name_handle;
            r_status   <= skrt_pkg::ST_DONE;
            r_fy       <= '0;
            r_fh       <= '0;
        end else begin
            if (i_cmd.st_we) begin
                r_status <= i_cmd.st_val;
            end
            if (i_cmd.cap_found) begin
                r_fy <= rd_rec.year;
                r_fh <= rd_rec.handle;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_year   <= r_fy;
            r_out_handle <= r_fh;
            r_out_used   <= skrt_pkg::USED_W'(r_cnt);
        end
    end

    assign ptr_x = {1'b0, r_ptr};
    assign cnt_x = {1'b0, r_cnt};

    always_comb begin
        o_sts.req_type  = r_req_type;
        o_sts.full      = (r_cnt == CW'(skrt_pkg::TABLE_DEPTH));
        o_sts.ptr_zero  = (r_ptr == '0);
        o_sts.ptr_ge2   = (r_ptr > CW'(1));
        o_sts.at_cnt    = (r_ptr == r_cnt);
        o_sts.last      = ((ptr_x + (CW+1)'(1)) == cnt_x);
        o_sts.p2_lt_cnt = ((ptr_x + (CW+1)'(2)) < cnt_x);
        o_sts.rd_vld    = r_rd_vld;
        o_sts.key_ge    = (rd_rec.key >= r_key);
        o_sts.key_eq    = (rd_rec.key == r_key);
        o_sts.out_free  = !r_out_valid || o_rsp.ready;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.found_year   = r_out_year;
    assign o_rsp.found_handle = r_out_handle;
    assign o_rsp.entries_used = r_out_used;

endmodule

[rtl/skrt_ctrl.sv]
// ----------------------------------------------------------------------------
// skrt_ctrl
// Request sequencer: dispatch, shift-up insert, scan, shift-down remove.
// ----------------------------------------------------------------------------
module skrt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  skrt_pkg::t_dp_sts  i_sts,
    output skrt_pkg::t_dp_cmd  o_cmd
);

    skrt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skrt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            skrt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = skrt_pkg::S_DISP;
            end
            skrt_pkg::S_DISP: begin
                case (i_sts.req_type)
                    skrt_pkg::REQ_INSERT: begin
                        n_state = i_sts.full ? skrt_pkg::S_DONE : skrt_pkg::S_INS;
                    end
                    skrt_pkg::REQ_LOOKUP, skrt_pkg::REQ_REMOVE: begin
                        n_state = skrt_pkg::S_FIND;
                    end
                    default: n_state = skrt_pkg::S_DONE;
                endcase
            end
            skrt_pkg::S_INS: begin
                if (i_sts.ptr_zero || (i_sts.rd_vld && !i_sts.key_ge)) begin
                    n_state = skrt_pkg::S_DONE;
                end
            end
            skrt_pkg::S_FIND: begin
                if (i_sts.at_cnt) begin
                    n_state = skrt_pkg::S_DONE;
                end else if (i_sts.rd_vld && i_sts.key_ge) begin
                    n_state = (i_sts.key_eq && i_sts.req_type == skrt_pkg::REQ_REMOVE) ?
                              skrt_pkg::S_DEL : skrt_pkg::S_DONE;
                end
            end
            skrt_pkg::S_DEL: begin
                if (i_sts.last) n_state = skrt_pkg::S_DONE;
            end
            skrt_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = skrt_pkg::S_IDLE;
            end
            default: n_state = skrt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = skrt_pkg::RA_AT;
        o_cmd.st_val = skrt_pkg::ST_DONE;
        o_in_ready   = 1'b0;
        case (r_state)
            skrt_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            skrt_pkg::S_DISP: begin
                case (i_sts.req_type)
                    skrt_pkg::REQ_INSERT: begin
                        o_cmd.st_we  = i_sts.full;
                        o_cmd.st_val = skrt_pkg::ST_FULL;
                    end
                    skrt_pkg::REQ_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                    end
                    default: ;
                endcase
            end
            skrt_pkg::S_INS: begin
                // walk down from the top, moving larger-or-equal keys up one slot
                o_cmd.rd_sel = skrt_pkg::RA_BELOW;
                if (i_sts.ptr_zero) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_new  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                end else if (!i_sts.rd_vld) begin
                    o_cmd.rd_en = 1'b1;
                end else if (i_sts.key_ge) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.ptr_dec = 1'b1;
                    o_cmd.rd_en   = i_sts.ptr_ge2;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_new  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            skrt_pkg::S_FIND: begin
                o_cmd.rd_sel = skrt_pkg::RA_AT;
                o_cmd.st_val = skrt_pkg::ST_NOT_FOUND;
                if (i_sts.at_cnt) begin
                    o_cmd.st_we = 1'b1;
                end else if (!i_sts.rd_vld) begin
                    o_cmd.rd_en = 1'b1;
                end else if (!i_sts.key_ge) begin
                    o_cmd.ptr_inc = 1'b1;
                    o_cmd.rd_en   = !i_sts.last;
                end else if (i_sts.key_eq) begin
                    o_cmd.cap_found = 1'b1;
                end else begin
                    o_cmd.st_we = 1'b1;
                end
            end
            skrt_pkg::S_DEL: begin
                o_cmd.rd_sel = skrt_pkg::RA_ABOVE;
                if (i_sts.last) begin
                    o_cmd.cnt_dec = 1'b1;
                end else if (!i_sts.rd_vld) begin
                    o_cmd.rd_en = 1'b1;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.ptr_inc = 1'b1;
                    o_cmd.rd_en   = i_sts.p2_lt_cnt;
                end
            end
            skrt_pkg::S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

[rtl/sorted_key_record_table_unit.sv]
// Timing: an insert, lookup or remove walks over the held records before its response is
// loaded; a clear or an insert into a full table goes from dispatch straight to the response;
// each can also wait for the response register to drain.
// Throughput: one request at a time; ready is high only while idle, from the cycle after the
// response is loaded, so a new request is not accepted until the last one has been answered.
// Reset: synchronous active low; clears the record count, sequencer and response valid.
// Table contents are not cleared and are read only below the count.
// ----------------------------------------------------------------------------
// sorted_key_record_table_unit
// Fixed-capacity table of records kept in ascending key order, with insert,
// lookup, remove and clear requests.
// ----------------------------------------------------------------------------
module sorted_key_record_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    skrt_req_if.sink    i_req,
    skrt_rsp_if.source  o_rsp
);

    skrt_pkg::t_dp_cmd   cmd;
    skrt_pkg::t_dp_sts   sts;
    skrt_pkg::t_req_item item;
    logic                in_ready;

    assign item = skrt_pkg::t_req_item'{i_req.req_type, i_req.key, i_req.year,
                                        i_req.name_handle};
    assign i_req.ready = in_ready;

    skrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    skrt_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr_en && cmd.wr_new) |-> !sts.full)
        else $error("new record written into a full table");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("response register overwritten before it was taken");

    a_dec_only_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cnt_dec |-> !sts.at_cnt)
        else $error("record count decremented past the scan pointer");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second request beat taken while one is in flight");

endmodule
